@@ hdl/clnf_pkg.sv @@
// Shared types, constants and helpers for the character-LCD number formatter.
package clnf_pkg;

    // Request action codes
    typedef enum logic [2:0] {
        ACT_CHAR = 3'd0,
        ACT_UDEC = 3'd1,
        ACT_SDEC = 3'd2,
        ACT_HEX  = 3'd3,
        ACT_BIN  = 3'd4
    } action_t;

    // What the back end has to do for a queued job
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_CHAR,
        KIND_DEC,
        KIND_HEX,
        KIND_BIN
    } job_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CMD,
        ST_SIGN,
        ST_DIGIT,
        ST_CHAR
    } state_t;

    localparam int MAG_W       = 17;            // magnitude of -32768 needs only 16 bits
    localparam int BCD_DIGITS  = 5;             // magnitudes top out at 65535, five digits
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] LINE2_OFFSET = 7'h40;
    localparam logic [7:0] CHR_ZERO     = 8'h30;
    localparam logic [7:0] CHR_A        = 8'h41;
    localparam logic [7:0] CHR_PLUS     = 8'h2B;
    localparam logic [7:0] CHR_MINUS    = 8'h2D;

    typedef struct packed {
        job_kind_t          kind;
        logic [7:0]         cmd_byte;
        logic               sign_en;
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [4:0]         ndig;
    } job_t;

    // Map a digit value to its upper-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
            ch = CHR_ZERO + {4'd0, d};
        else
            ch = CHR_A + {4'd0, d - 4'd10};
        return ch;
    endfunction

endpackage

@@ hdl/clnf_front.sv @@
// Front end: classify a request into a job for the back end.
module clnf_front
    import clnf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic [2:0]  action,
    input  logic [1:0]  row,
    input  logic [4:0]  col,
    input  logic [15:0] value,
    input  logic [4:0]  digit_count,
    output job_t        job
);

    localparam logic [4:0] MAX_CNT = 5'(MAX_DIGITS);

    logic [6:0] addr;

    always_comb
    begin
        // address wraps modulo 128
        addr = {2'b00, col} + 7'h7F + ((row == 2'd1) ? 7'h00 : LINE2_OFFSET);

        job.cmd_byte = CMD_SET_ADDR | {1'b0, addr};
        job.ndig     = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;
        job.sign_en  = 1'b0;
        job.neg      = 1'b0;
        job.mag      = {1'b0, value};

        case (action)
            ACT_CHAR: job.kind = KIND_CHAR;
            ACT_UDEC: job.kind = KIND_DEC;
            ACT_SDEC:
            begin
                job.kind    = KIND_DEC;
                job.sign_en = (value != 16'd0);
                job.neg     = value[15];
                if (value[15])
                    job.mag = 17'h10000 - {1'b0, value};
            end
            ACT_HEX:  job.kind = KIND_HEX;
            ACT_BIN:  job.kind = KIND_BIN;
            default:  job.kind = KIND_NONE;
        endcase
    end

endmodule

@@ hdl/clnf_queue.sv @@
// Short job queue between the front end and the back end.
module clnf_queue
    import clnf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full   = (cnt_reg == FULL_CNT);
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

@@ hdl/clnf_back.sv @@
// Back end: binary-to-BCD conversion and sequencing of LCD bus writes.
module clnf_back
    import clnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_take,
    output logic       empty,
    input  logic       pop,
    output logic       is_data,
    output logic [7:0] bus_byte,
    output logic       last
);

    state_t            state_reg, state_next;
    job_kind_t         kind_reg, kind_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic              sign_en_reg, sign_en_next;
    logic              neg_reg, neg_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [4:0]        bit_cnt_reg, bit_cnt_next;
    logic [4:0]        remaining_reg, remaining_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_data_reg, out_data_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              emit;
    logic              emit_data;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic [BCD_W-1:0]  bcd_adj;
    logic [3:0]        pos;
    logic [3:0]        digit;

    localparam logic [4:0] CONV_LAST = 5'(MAG_W - 1);

    assign empty    = !out_valid_reg;
    assign is_data  = out_data_reg;
    assign bus_byte = out_byte_reg;
    assign last     = out_last_reg;
    assign out_free = !out_valid_reg || pop;

    // Double-dabble adjust: add 3 to every BCD digit of 5 or more
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // Pick the digit at the current position; positions past the value show zero
    always_comb
    begin
        pos   = 4'(remaining_reg - 5'd1);
        digit = 4'd0;
        case (kind_reg)
            KIND_DEC:
            begin
                for (int d = 0; d < BCD_DIGITS; d++)
                    if (pos == 4'(d))
                        digit = bcd_reg[4*d +: 4];
            end
            KIND_HEX:
            begin
                for (int d = 0; d < BCD_DIGITS; d++)
                    if (pos == 4'(d))
                        digit = 4'({{(BCD_W - MAG_W){1'b0}}, mag_reg} >> (4 * d));
            end
            KIND_BIN: digit = {3'd0, mag_reg[pos]};
            default:  digit = 4'd0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd_next       = cmd_reg;
        sign_en_next   = sign_en_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        remaining_next = remaining_reg;
        job_take       = 1'b0;
        emit           = 1'b0;
        emit_data      = 1'b1;
        emit_byte      = 8'd0;
        emit_last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take       = 1'b1;
                    kind_next      = job.kind;
                    cmd_next       = job.cmd_byte;
                    sign_en_next   = job.sign_en;
                    neg_next       = job.neg;
                    mag_next       = job.mag;
                    remaining_next = job.ndig;
                    bcd_next       = '0;
                    bit_cnt_next   = '0;
                    state_next     = (job.kind == KIND_DEC) ? ST_CONV : ST_CMD;
                end
            end
            ST_CONV:
            begin
                // shift one magnitude bit into the BCD register
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == CONV_LAST)
                    state_next = ST_CMD;
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_data = 1'b0;
                    emit_byte = cmd_reg;
                    if (kind_reg == KIND_CHAR)
                        state_next = ST_CHAR;
                    else if (kind_reg == KIND_NONE)
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (sign_en_reg)
                        state_next = ST_SIGN;
                    else if (remaining_reg != 5'd0)
                        state_next = ST_DIGIT;
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = neg_reg ? CHR_MINUS : CHR_PLUS;
                    emit_last = (remaining_reg == 5'd0);
                    state_next = emit_last ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_byte      = digit_char(digit);
                    emit_last      = (remaining_reg == 5'd1);
                    remaining_next = remaining_reg - 5'd1;
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = mag_reg[7:0];
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        cmd_reg       <= cmd_next;
        sign_en_reg   <= sign_en_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        bit_cnt_reg   <= bit_cnt_next;
        remaining_reg <= remaining_next;
        out_data_reg  <= out_data_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> bit_cnt_reg <= CONV_LAST)
        else $error("conversion ran past the magnitude width");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> state_reg == ST_IDLE && job_valid)
        else $error("job taken while busy or queue empty");

    a_digit_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> remaining_reg != 5'd0)
        else $error("digit state with no digits left");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_byte_reg)
                                  && $stable(out_last_reg))
        else $error("pending write overwritten");

endmodule

@@ hdl/char_lcd_number_formatter_core.sv @@
// Top level of the character-LCD number formatter: front end, job queue, back end.
//
//  channel   direction  handshake          payload
//  request   in         push / full        action, row, col, value, digit_count
//  bus write out        empty / pop        is_data, bus_byte, last
//
// A request yields 1 to 18 bus writes: the set-address command, then one
// character, or an optional sign and digit_count digits.
// Decimal requests are loaded and then pass through the shift-and-add-3
// BCD converter before the first write; other actions write after the load.
// After that the back end issues one write per cycle while pop keeps up.
// The job queue holds two classified requests, so the front end keeps taking
// requests while the back end works or waits on a stalled output.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
module char_lcd_number_formatter_core
    import clnf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic [1:0]  row,
    input  logic [4:0]  col,
    input  logic [15:0] value,
    input  logic [4:0]  digit_count,
    output logic        empty,
    input  logic        pop,
    output logic        is_data,
    output logic [7:0]  bus_byte,
    output logic        last
);

    job_t front_job;
    job_t queue_job;
    logic queue_empty;
    logic job_take;
    logic push_ok;

    // accept an item only when the queue has room
    assign push_ok = push && !full;

    // classify: address command, digit source, sign, saturated digit count
    clnf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .action      (action),
        .row         (row),
        .col         (col),
        .value       (value),
        .digit_count (digit_count),
        .job         (front_job)
    );

    // decouple request acceptance from the slow write sequence
    clnf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push_ok),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (job_take),
        .rd_job (queue_job),
        .empty  (queue_empty)
    );

    // convert and sequence the bus writes into the output register
    clnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!queue_empty),
        .job       (queue_job),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .is_data   (is_data),
        .bus_byte  (bus_byte),
        .last      (last)
    );

endmodule
